FILE: rtl/sdi_pkg.sv
// Shared types and constants for the SD/MMC card bring-up sequencer.
// Used by sdi_step and sd_mmc_card_init_sequencer; depends on nothing.
package sdi_pkg;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_CMD0   = 4'd1,
        PH_CMD8   = 4'd2,
        PH_APP41  = 4'd3,
        PH_ACMD41 = 4'd4,
        PH_CMD1   = 4'd5,
        PH_CMD2   = 4'd6,
        PH_CMD3   = 4'd7,
        PH_CMD9   = 4'd8,
        PH_CMD7   = 4'd9,
        PH_APP6   = 4'd10,
        PH_ACMD6  = 4'd11,
        PH_CMD16  = 4'd12,
        PH_READY  = 4'd13,
        PH_FAILED = 4'd14
    } phase_t;

    localparam logic [1:0] RK_NONE  = 2'd0;
    localparam logic [1:0] RK_SHORT = 2'd1;
    localparam logic [1:0] RK_BUSY  = 2'd2;
    localparam logic [1:0] RK_LONG  = 2'd3;

    localparam logic [1:0] ST_BUSY   = 2'd0;
    localparam logic [1:0] ST_READY  = 2'd1;
    localparam logic [1:0] ST_FAILED = 2'd2;

    localparam logic       REQ_START    = 1'b0;
    localparam logic       REQ_COMPLETE = 1'b1;

    localparam logic [1:0] CFG_SD_V1_RETRY = 2'd0;
    localparam logic [1:0] CFG_SD_V2_RETRY = 2'd1;
    localparam logic [1:0] CFG_MMC_RETRY   = 2'd2;
    localparam logic [1:0] CFG_BLOCK_LEN   = 2'd3;

    localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
    localparam logic [5:0] CMD_SEND_OP   = 6'd1;
    localparam logic [5:0] CMD_ALL_CID   = 6'd2;
    localparam logic [5:0] CMD_REL_ADDR  = 6'd3;
    localparam logic [5:0] CMD_BUS_WIDTH = 6'd6;
    localparam logic [5:0] CMD_SELECT    = 6'd7;
    localparam logic [5:0] CMD_IF_COND   = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD  = 6'd9;
    localparam logic [5:0] CMD_BLOCK_LEN = 6'd16;
    localparam logic [5:0] CMD_SD_OP     = 6'd41;
    localparam logic [5:0] CMD_APP       = 6'd55;

    localparam logic [31:0] IF_COND_ARG   = 32'h0000_01aa;
    localparam logic [8:0]  IF_COND_ECHO  = 9'h1aa;
    localparam logic [31:0] OCR_ARG_HCS   = 32'h4030_0000;
    localparam logic [31:0] OCR_ARG_STD   = 32'h0030_0000;
    localparam logic [3:0]  CSD_V2_NIBBLE = 4'h4;
    localparam logic [15:0] BUS_4BIT_ARG  = 16'h0002;

    localparam logic [5:0]  SD_V1_RETRY_RST = 6'd10;
    localparam logic [5:0]  SD_V2_RETRY_RST = 6'd50;
    localparam logic [5:0]  MMC_RETRY_RST   = 6'd10;
    localparam logic [12:0] BLOCK_LEN_RST   = 13'd512;

    typedef struct packed {
        logic        req_type;
        logic        cmd_ok;
        logic [31:0] resp_word;
    } req_item_t;

    typedef struct packed {
        logic        cmd_valid;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_arg;
        logic [1:0]  resp_kind;
        logic        delay_first;
        logic [1:0]  init_status;
        logic        card_is_sd;
        logic        card_is_sdhc;
        logic [15:0] card_rca;
    } rsp_item_t;

    typedef struct packed {
        logic [5:0]  sd_v1_retry_limit;
        logic [5:0]  sd_v2_retry_limit;
        logic [5:0]  mmc_retry_limit;
        logic [12:0] block_length;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [5:0]  retries_left;
        logic        version2_flag;
        logic        sd_flag;
        logic        high_capacity_flag;
        logic [15:0] relative_address;
    } card_state_t;

endpackage

FILE: rtl/sdi_step.sv
// Next-state and command decision for one request item.
// Depends on sdi_pkg for the item, config and card state types.
module sdi_step (
    input  sdi_pkg::card_state_t cur,
    input  sdi_pkg::cfg_t        cfg,
    input  sdi_pkg::req_item_t   req,
    output sdi_pkg::card_state_t nxt,
    output sdi_pkg::rsp_item_t   rsp
);

    logic        v2;
    logic [5:0]  limit;
    logic        op_done;
    logic [31:0] rca_arg;
    logic [31:0] blk_arg;

    always_comb
    begin
        v2      = req.cmd_ok && (req.resp_word[8:0] == sdi_pkg::IF_COND_ECHO);
        limit   = v2 ? cfg.sd_v2_retry_limit : cfg.sd_v1_retry_limit;
        op_done = req.cmd_ok && req.resp_word[31];
        rca_arg = {cur.relative_address, 16'h0000};
        blk_arg = {19'd0, cfg.block_length};

        nxt = cur;
        rsp = '0;

        if (req.req_type == sdi_pkg::REQ_START)
        begin
            nxt.retries_left       = '0;
            nxt.version2_flag      = 1'b0;
            nxt.sd_flag            = 1'b0;
            nxt.high_capacity_flag = 1'b0;
            nxt.relative_address   = '0;
            nxt.phase              = sdi_pkg::PH_CMD0;
            rsp.cmd_valid          = 1'b1;
            rsp.cmd_index          = sdi_pkg::CMD_GO_IDLE;
            rsp.resp_kind          = sdi_pkg::RK_NONE;
        end
        else
        begin
            case (cur.phase)
                sdi_pkg::PH_CMD0:
                begin
                    nxt.phase     = sdi_pkg::PH_CMD8;
                    rsp.cmd_valid = 1'b1;
                    rsp.cmd_index = sdi_pkg::CMD_IF_COND;
                    rsp.cmd_arg   = sdi_pkg::IF_COND_ARG;
                    rsp.resp_kind = sdi_pkg::RK_SHORT;
                end
                sdi_pkg::PH_CMD8:
                begin
                    nxt.version2_flag = v2;
                    if (limit == 6'd0)
                    begin
                        if (cfg.mmc_retry_limit == 6'd0)
                        begin
                            nxt.retries_left = '0;
                            nxt.phase        = sdi_pkg::PH_FAILED;
                        end
                        else
                        begin
                            nxt.retries_left = cfg.mmc_retry_limit - 6'd1;
                            nxt.phase        = sdi_pkg::PH_CMD1;
                            rsp.cmd_valid    = 1'b1;
                            rsp.cmd_index    = sdi_pkg::CMD_SEND_OP;
                            rsp.resp_kind    = sdi_pkg::RK_SHORT;
                        end
                    end
                    else
                    begin
                        nxt.retries_left = limit - 6'd1;
                        nxt.phase        = sdi_pkg::PH_APP41;
                        rsp.cmd_valid    = 1'b1;
                        rsp.cmd_index    = sdi_pkg::CMD_APP;
                        rsp.resp_kind    = sdi_pkg::RK_SHORT;
                    end
                end
                sdi_pkg::PH_APP41:
                begin
                    nxt.phase     = sdi_pkg::PH_ACMD41;
                    rsp.cmd_valid = 1'b1;
                    rsp.cmd_index = sdi_pkg::CMD_SD_OP;
                    rsp.cmd_arg   = cur.version2_flag ? sdi_pkg::OCR_ARG_HCS
                                                      : sdi_pkg::OCR_ARG_STD;
                    rsp.resp_kind = sdi_pkg::RK_SHORT;
                end
                sdi_pkg::PH_ACMD41:
                begin
                    if (op_done)
                    begin
                        nxt.sd_flag   = 1'b1;
                        nxt.phase     = sdi_pkg::PH_CMD2;
                        rsp.cmd_valid = 1'b1;
                        rsp.cmd_index = sdi_pkg::CMD_ALL_CID;
                        rsp.resp_kind = sdi_pkg::RK_LONG;
                    end
                    else if (cur.retries_left != 6'd0)
                    begin
                        nxt.retries_left = cur.retries_left - 6'd1;
                        nxt.phase        = sdi_pkg::PH_APP41;
                        rsp.cmd_valid    = 1'b1;
                        rsp.cmd_index    = sdi_pkg::CMD_APP;
                        rsp.resp_kind    = sdi_pkg::RK_SHORT;
                        rsp.delay_first  = 1'b1;
                    end
                    else if (cfg.mmc_retry_limit == 6'd0)
                    begin
                        nxt.retries_left = '0;
                        nxt.phase        = sdi_pkg::PH_FAILED;
                    end
                    else
                    begin
                        nxt.retries_left = cfg.mmc_retry_limit - 6'd1;
                        nxt.phase        = sdi_pkg::PH_CMD1;
                        rsp.cmd_valid    = 1'b1;
                        rsp.cmd_index    = sdi_pkg::CMD_SEND_OP;
                        rsp.resp_kind    = sdi_pkg::RK_SHORT;
                        rsp.delay_first  = 1'b1;
                    end
                end
                sdi_pkg::PH_CMD1:
                begin
                    if (op_done)
                    begin
                        nxt.phase     = sdi_pkg::PH_CMD2;
                        rsp.cmd_valid = 1'b1;
                        rsp.cmd_index = sdi_pkg::CMD_ALL_CID;
                        rsp.resp_kind = sdi_pkg::RK_LONG;
                    end
                    else if (cur.retries_left != 6'd0)
                    begin
                        nxt.retries_left = cur.retries_left - 6'd1;
                        nxt.phase        = sdi_pkg::PH_CMD1;
                        rsp.cmd_valid    = 1'b1;
                        rsp.cmd_index    = sdi_pkg::CMD_SEND_OP;
                        rsp.resp_kind    = sdi_pkg::RK_SHORT;
                        rsp.delay_first  = 1'b1;
                    end
                    else
                    begin
                        nxt.phase = sdi_pkg::PH_FAILED;
                    end
                end
                sdi_pkg::PH_CMD2:
                begin
                    if (!req.cmd_ok)
                    begin
                        nxt.phase = sdi_pkg::PH_FAILED;
                    end
                    else
                    begin
                        nxt.phase     = sdi_pkg::PH_CMD3;
                        rsp.cmd_valid = 1'b1;
                        rsp.cmd_index = sdi_pkg::CMD_REL_ADDR;
                        rsp.resp_kind = sdi_pkg::RK_SHORT;
                    end
                end
                sdi_pkg::PH_CMD3:
                begin
                    if (!req.cmd_ok)
                    begin
                        nxt.phase = sdi_pkg::PH_FAILED;
                    end
                    else
                    begin
                        nxt.relative_address = cur.sd_flag ? req.resp_word[31:16] : 16'h0000;
                        nxt.phase            = sdi_pkg::PH_CMD9;
                        rsp.cmd_valid        = 1'b1;
                        rsp.cmd_index        = sdi_pkg::CMD_SEND_CSD;
                        rsp.cmd_arg          = {nxt.relative_address, 16'h0000};
                        rsp.resp_kind        = sdi_pkg::RK_LONG;
                    end
                end
                sdi_pkg::PH_CMD9:
                begin
                    if (!req.cmd_ok)
                    begin
                        nxt.phase = sdi_pkg::PH_FAILED;
                    end
                    else
                    begin
                        nxt.high_capacity_flag =
                            (req.resp_word[31:28] == sdi_pkg::CSD_V2_NIBBLE);
                        nxt.phase     = sdi_pkg::PH_CMD7;
                        rsp.cmd_valid = 1'b1;
                        rsp.cmd_index = sdi_pkg::CMD_SELECT;
                        rsp.cmd_arg   = rca_arg;
                        rsp.resp_kind = sdi_pkg::RK_BUSY;
                    end
                end
                sdi_pkg::PH_CMD7:
                begin
                    if (!req.cmd_ok)
                    begin
                        nxt.phase = sdi_pkg::PH_FAILED;
                    end
                    else if (cur.sd_flag)
                    begin
                        nxt.phase     = sdi_pkg::PH_APP6;
                        rsp.cmd_valid = 1'b1;
                        rsp.cmd_index = sdi_pkg::CMD_APP;
                        rsp.cmd_arg   = rca_arg;
                        rsp.resp_kind = sdi_pkg::RK_SHORT;
                    end
                    else
                    begin
                        nxt.phase     = sdi_pkg::PH_CMD16;
                        rsp.cmd_valid = 1'b1;
                        rsp.cmd_index = sdi_pkg::CMD_BLOCK_LEN;
                        rsp.cmd_arg   = blk_arg;
                        rsp.resp_kind = sdi_pkg::RK_SHORT;
                    end
                end
                sdi_pkg::PH_APP6:
                begin
                    if (!req.cmd_ok)
                    begin
                        nxt.phase = sdi_pkg::PH_FAILED;
                    end
                    else
                    begin
                        nxt.phase     = sdi_pkg::PH_ACMD6;
                        rsp.cmd_valid = 1'b1;
                        rsp.cmd_index = sdi_pkg::CMD_BUS_WIDTH;
                        rsp.cmd_arg   = {cur.relative_address, sdi_pkg::BUS_4BIT_ARG};
                        rsp.resp_kind = sdi_pkg::RK_SHORT;
                    end
                end
                sdi_pkg::PH_ACMD6:
                begin
                    if (!req.cmd_ok)
                    begin
                        nxt.phase = sdi_pkg::PH_FAILED;
                    end
                    else
                    begin
                        nxt.phase     = sdi_pkg::PH_CMD16;
                        rsp.cmd_valid = 1'b1;
                        rsp.cmd_index = sdi_pkg::CMD_BLOCK_LEN;
                        rsp.cmd_arg   = blk_arg;
                        rsp.resp_kind = sdi_pkg::RK_SHORT;
                    end
                end
                sdi_pkg::PH_CMD16:
                begin
                    nxt.phase = req.cmd_ok ? sdi_pkg::PH_READY : sdi_pkg::PH_FAILED;
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
        end

        if (nxt.phase == sdi_pkg::PH_READY)
        begin
            rsp.init_status = sdi_pkg::ST_READY;
        end
        else if (nxt.phase == sdi_pkg::PH_FAILED)
        begin
            rsp.init_status = sdi_pkg::ST_FAILED;
        end
        else
        begin
            rsp.init_status = sdi_pkg::ST_BUSY;
        end
        rsp.card_is_sd   = nxt.sd_flag;
        rsp.card_is_sdhc = nxt.high_capacity_flag;
        rsp.card_rca     = nxt.relative_address;
    end

endmodule

FILE: rtl/sd_mmc_card_init_sequencer.sv
// Top level of the SD/MMC card bring-up sequencer: input register, card state,
// configuration registers and result register. Depends on sdi_pkg and sdi_step.
//
//   channel  signals                        direction  item
//   req      req_valid, req_stall, req      in         start or command completion
//   rsp      rsp_valid, rsp_stall, rsp      out        next command and card status
//   cfg      cfg_we, cfg_index, cfg_data    in         retry limits, block length
//
// One item per cycle unless rsp stalls; an item taken on req goes into the input
// register, then the result register, which drives rsp. The card state updates as
// the item moves from the input register to the result register, so consecutive
// items see each other's effects. A stall on rsp with a full result register holds
// both registers and raises req_stall once the input register is full. Reset
// clears the card state and loads default limits.
module sd_mmc_card_init_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  sdi_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output sdi_pkg::rsp_item_t rsp,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_data
);

    logic                 in_valid_reg;
    sdi_pkg::req_item_t   in_item_reg;
    logic                 out_valid_reg;
    sdi_pkg::rsp_item_t   out_item_reg;
    sdi_pkg::card_state_t state_reg;
    sdi_pkg::card_state_t state_next;
    sdi_pkg::cfg_t        cfg_reg;
    sdi_pkg::rsp_item_t   step_rsp;
    logic                 advance;

    assign advance   = in_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !advance;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    sdi_step u_step (
        .cur (state_reg),
        .cfg (cfg_reg),
        .req (in_item_reg),
        .nxt (state_next),
        .rsp (step_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!req_stall)
            begin
                in_valid_reg <= req_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!req_stall && req_valid)
        begin
            in_item_reg <= req;
        end
        if (advance)
        begin
            out_item_reg <= step_rsp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase              <= sdi_pkg::PH_IDLE;
            state_reg.retries_left       <= '0;
            state_reg.version2_flag      <= 1'b0;
            state_reg.sd_flag            <= 1'b0;
            state_reg.high_capacity_flag <= 1'b0;
            state_reg.relative_address   <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sd_v1_retry_limit <= sdi_pkg::SD_V1_RETRY_RST;
            cfg_reg.sd_v2_retry_limit <= sdi_pkg::SD_V2_RETRY_RST;
            cfg_reg.mmc_retry_limit   <= sdi_pkg::MMC_RETRY_RST;
            cfg_reg.block_length      <= sdi_pkg::BLOCK_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sdi_pkg::CFG_SD_V1_RETRY: cfg_reg.sd_v1_retry_limit <= cfg_data[5:0];
                sdi_pkg::CFG_SD_V2_RETRY: cfg_reg.sd_v2_retry_limit <= cfg_data[5:0];
                sdi_pkg::CFG_MMC_RETRY:   cfg_reg.mmc_retry_limit   <= cfg_data[5:0];
                sdi_pkg::CFG_BLOCK_LEN:   cfg_reg.block_length      <= cfg_data;
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_item_reg.cmd_valid) |->
            (out_item_reg.cmd_index == 6'd0 && out_item_reg.cmd_arg == 32'd0 &&
             out_item_reg.resp_kind == sdi_pkg::RK_NONE && !out_item_reg.delay_first))
        else $error("command fields set without a command");

    a_done_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_item_reg.init_status == sdi_pkg::ST_READY ||
                           out_item_reg.init_status == sdi_pkg::ST_FAILED)) |->
            !out_item_reg.cmd_valid)
        else $error("command issued with final status");

    a_mmc_no_rca: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.sd_flag |-> (state_reg.relative_address == 16'h0000))
        else $error("nonzero RCA for a card not detected as SD");

    a_advance_updates: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed item did not reach the result register");

endmodule
